>>> rtl/paged_bitmap_slot_allocator_defines.svh
// -----------------------------------------------------------------------------
// Paged bitmap slot allocator assertion macros
// Shorthand for clocked assertions, disabled while reset is held.
// -----------------------------------------------------------------------------
`ifndef PAGED_BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define PAGED_BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pbsa_pkg.sv
// -----------------------------------------------------------------------------
// Paged bitmap slot allocator package
// Field widths, operation and status codes, register indexes and shared types.
// -----------------------------------------------------------------------------
`default_nettype none

package pbsa_pkg;

  localparam int IDX_W          = 11;
  localparam int OP_W           = 2;
  localparam int ST_W           = 2;
  localparam int ADDR_W         = 32;
  localparam int BIT_W          = 6;
  localparam int PAGE_W         = IDX_W - BIT_W;
  localparam int SLOTS_PER_PAGE = 64;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 16;
  localparam int HDR_W          = 8;
  localparam int SLOT_W         = 8;
  localparam int IN_TDATA_W     = 16;
  localparam int IN_TUSER_W     = 2;
  localparam int OUT_TDATA_W    = 80;
  localparam int OUT_TUSER_W    = 3;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_XLATE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_AW-1:0] REG_START_ADDR  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ROOT_OFFSET = 3'd1;
  localparam logic [CFG_AW-1:0] REG_PAGE_BYTES  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_HDR_BYTES   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SLOT_BYTES  = 3'd4;

  localparam logic [CFG_DW-1:0] RST_START_ADDR  = 16'd64;
  localparam logic [CFG_DW-1:0] RST_ROOT_OFFSET = 16'd16;
  localparam logic [CFG_DW-1:0] RST_PAGE_BYTES  = 16'd1552;
  localparam logic [HDR_W-1:0]  RST_HDR_BYTES   = 8'd16;
  localparam logic [SLOT_W-1:0] RST_SLOT_BYTES  = 8'd24;

  typedef enum logic [2:0] {
    K_ALLOC = 3'd0,
    K_CLEAR = 3'd1,
    K_ROOT  = 3'd2,
    K_FREE  = 3'd3,
    K_XLATE = 3'd4,
    K_BAD   = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   idx;
    logic [PAGE_W-1:0]  page;
    logic [BIT_W-1:0]   bit_sel;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } fe_out_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  result_index;
    logic [ADDR_W-1:0] slot_address;
    logic              page_added;
    logic [ADDR_W-1:0] new_page_address;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/pbsa_ram.sv
// -----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module pbsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/pbsa_front.sv
// -----------------------------------------------------------------------------
// Slot allocator request front end
// Accepts request words, decodes them and queues them for the back end.
// -----------------------------------------------------------------------------
`default_nettype none

module pbsa_front
  import pbsa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [IDX_W-1:0]  in_idx,
  output fe_out_t                fe_o,
  input  wire logic              fe_pop
);

  localparam logic [1:0] QFULL = 2'd2;

  req_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  req_t       dec;
  logic [IDX_W-1:0] idx_m1;
  logic       idx_zero;
  logic       push;
  logic       pop;

  assign idx_m1   = in_idx - IDX_W'(1);
  assign idx_zero = (in_idx == '0);

  always_comb begin
    dec.idx     = in_idx;
    dec.page    = idx_m1[IDX_W-1:BIT_W];
    dec.bit_sel = idx_m1[BIT_W-1:0];
    case (in_op)
      OP_ALLOC: begin
        dec.kind = K_ALLOC;
      end
      OP_FREE: begin
        dec.kind = idx_zero ? K_CLEAR : K_FREE;
      end
      OP_XLATE: begin
        dec.kind = idx_zero ? K_ROOT : K_XLATE;
      end
      default: begin
        dec.kind = K_BAD;
      end
    endcase
  end

  assign in_ready   = (cnt_r != QFULL);
  assign push       = in_valid && in_ready;
  assign pop        = fe_pop && (cnt_r != 2'd0);
  assign fe_o.valid = (cnt_r != 2'd0);
  assign fe_o.req   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pbsa_back.sv
// -----------------------------------------------------------------------------
// Slot allocator back end
// Holds the page state and runs allocate, free and translate requests.
// -----------------------------------------------------------------------------
`default_nettype none

module pbsa_back
  import pbsa_pkg::*;
#(
  parameter int MAX_PAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_AW-1:0]  cfg_addr,
  input  wire logic [CFG_DW-1:0]  cfg_wdata,
  input  wire fe_out_t            fe_i,
  output logic                    fe_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output result_t                 res_o
);

  localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int CMP_W  = (CNT_W > PAGE_W) ? CNT_W : PAGE_W;
  localparam int CHUNK  = 16;
  localparam int POS_W  = 4;
  localparam int NCHUNK = (MAX_PAGES + CHUNK - 1) / CHUNK;
  localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PROD_W = BIT_W + SLOT_W;
  localparam int MAP_W  = SLOTS_PER_PAGE;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_RD   = 6'b000100,
    S_DATA = 6'b001000,
    S_ADDR = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  end_r, end_nxt;
  logic [MAX_PAGES-1:0] full_r, full_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CFG_DW-1:0]  start_r, start_nxt;
  logic [CFG_DW-1:0]  root_r, root_nxt;
  logic [CFG_DW-1:0]  pbytes_r, pbytes_nxt;
  logic [HDR_W-1:0]   hdr_r, hdr_nxt;
  logic [SLOT_W-1:0]  sbytes_r, sbytes_nxt;

  kind_t              kind_r, kind_nxt;
  logic [PG_W-1:0]    page_r, page_nxt;
  logic [BIT_W-1:0]   bpos_r, bpos_nxt;
  logic [CH_W-1:0]    chunk_r, chunk_nxt;
  logic [ST_W-1:0]    status_r, status_nxt;
  logic [IDX_W-1:0]   resid_r, resid_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic               added_r, added_nxt;
  logic [ADDR_W-1:0]  newbase_r, newbase_nxt;
  result_t            res_r, res_nxt;

  logic [NCHUNK*CHUNK-1:0] avail;
  logic [CHUNK-1:0]   chunk_bits;
  logic               found_any;
  logic [POS_W-1:0]   found_pos;
  logic [PG_W-1:0]    scan_page;
  logic [BIT_W-1:0]   ffz_pos;
  logic               cnt_full;
  logic               out_free;
  logic               in_range;
  logic [PROD_W-1:0]  prod;
  logic [ADDR_W-1:0]  base_sel;

  logic               map_we;
  logic [PG_W-1:0]    map_waddr;
  logic [MAP_W-1:0]   map_wdata;
  logic [MAP_W-1:0]   map_rdata;
  logic               base_we;
  logic [ADDR_W-1:0]  base_rdata;
  logic               rd_en;

  pbsa_ram #(
    .WIDTH (MAP_W),
    .DEPTH (MAX_PAGES)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (rd_en),
    .raddr (page_r),
    .rdata (map_rdata)
  );

  pbsa_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_PAGES)
  ) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .waddr (PG_W'(cnt_r)),
    .wdata (end_r),
    .re    (rd_en),
    .raddr (page_r),
    .rdata (base_rdata)
  );

  for (genvar g = 0; g < NCHUNK * CHUNK; g++) begin : g_avail
    if (g < MAX_PAGES) begin : g_live
      assign avail[g] = (CNT_W'(g) < cnt_r) && !full_r[g];
    end else begin : g_pad
      assign avail[g] = 1'b0;
    end
  end

  assign chunk_bits = avail[chunk_r*CHUNK +: CHUNK];
  assign found_any  = |chunk_bits;
  assign scan_page  = PG_W'({chunk_r, found_pos});
  assign cnt_full   = (cnt_r == CNT_W'(MAX_PAGES));
  assign out_free   = !out_valid_r || out_ready;
  assign in_range   = CMP_W'(fe_i.req.page) < CMP_W'(cnt_r);
  assign prod       = {{SLOT_W{1'b0}}, bpos_r} * {{BIT_W{1'b0}}, sbytes_r};
  assign base_sel   = added_r ? newbase_r : base_rdata;
  assign map_waddr  = (state_r == S_SCAN) ? PG_W'(cnt_r) : page_r;

  always_comb begin
    found_pos = '0;
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (chunk_bits[j]) begin
        found_pos = POS_W'(j);
      end
    end
  end

  always_comb begin
    ffz_pos = '0;
    for (int j = MAP_W - 1; j >= 0; j--) begin
      if (!map_rdata[j]) begin
        ffz_pos = BIT_W'(j);
      end
    end
  end

  always_comb begin
    start_nxt  = start_r;
    root_nxt   = root_r;
    pbytes_nxt = pbytes_r;
    hdr_nxt    = hdr_r;
    sbytes_nxt = sbytes_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_START_ADDR:  start_nxt  = cfg_wdata;
        REG_ROOT_OFFSET: root_nxt   = cfg_wdata;
        REG_PAGE_BYTES:  pbytes_nxt = cfg_wdata;
        REG_HDR_BYTES:   hdr_nxt    = cfg_wdata[HDR_W-1:0];
        REG_SLOT_BYTES:  sbytes_nxt = cfg_wdata[SLOT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    end_nxt       = end_r;
    full_nxt      = full_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    kind_nxt      = kind_r;
    page_nxt      = page_r;
    bpos_nxt      = bpos_r;
    chunk_nxt     = chunk_r;
    status_nxt    = status_r;
    resid_nxt     = resid_r;
    addr_nxt      = addr_r;
    added_nxt     = added_r;
    newbase_nxt   = newbase_r;
    res_nxt       = res_r;
    fe_pop        = 1'b0;
    map_we        = 1'b0;
    map_wdata     = map_rdata;
    base_we       = 1'b0;
    rd_en         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (fe_i.valid) begin
          fe_pop      = 1'b1;
          kind_nxt    = fe_i.req.kind;
          page_nxt    = PG_W'(fe_i.req.page);
          bpos_nxt    = fe_i.req.bit_sel;
          chunk_nxt   = '0;
          status_nxt  = ST_OK;
          resid_nxt   = fe_i.req.idx;
          addr_nxt    = '0;
          added_nxt   = 1'b0;
          newbase_nxt = '0;
          case (fe_i.req.kind)
            K_ALLOC: begin
              resid_nxt = '0;
              state_nxt = S_SCAN;
            end
            K_CLEAR: begin
              cnt_nxt   = '0;
              end_nxt   = ADDR_W'(start_r);
              full_nxt  = '0;
              state_nxt = S_DONE;
            end
            K_ROOT: begin
              addr_nxt  = ADDR_W'(root_r);
              state_nxt = S_DONE;
            end
            K_FREE, K_XLATE: begin
              if (in_range) begin
                state_nxt = S_RD;
              end else begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end
            end
            default: begin
              status_nxt = ST_RANGE;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (found_any) begin
          page_nxt  = scan_page;
          state_nxt = S_RD;
        end else if (chunk_r == CH_W'(NCHUNK - 1)) begin
          if (!cnt_full) begin
            map_we                  = 1'b1;
            map_wdata               = MAP_W'(1);
            base_we                 = 1'b1;
            full_nxt[PG_W'(cnt_r)]  = 1'b0;
            page_nxt                = PG_W'(cnt_r);
            bpos_nxt                = '0;
            added_nxt               = 1'b1;
            newbase_nxt             = end_r;
            end_nxt                 = end_r + ADDR_W'(pbytes_r);
            cnt_nxt                 = cnt_r + CNT_W'(1);
            state_nxt               = S_ADDR;
          end else begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end
        end else begin
          chunk_nxt = chunk_r + CH_W'(1);
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_DATA;
      end
      S_DATA: begin
        case (kind_r)
          K_ALLOC: begin
            map_we           = 1'b1;
            map_wdata        = map_rdata | (MAP_W'(1) << ffz_pos);
            full_nxt[page_r] = &map_wdata;
            bpos_nxt         = ffz_pos;
            state_nxt        = S_ADDR;
          end
          K_FREE: begin
            map_we           = 1'b1;
            map_wdata        = map_rdata & ~(MAP_W'(1) << bpos_r);
            full_nxt[page_r] = 1'b0;
            state_nxt        = S_DONE;
          end
          default: begin
            state_nxt = S_ADDR;
          end
        endcase
      end
      S_ADDR: begin
        addr_nxt = base_sel + ADDR_W'(hdr_r) + ADDR_W'(prod);
        if (kind_r == K_ALLOC) begin
          resid_nxt = IDX_W'({page_r, bpos_r}) + IDX_W'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          res_nxt.status           = status_r;
          res_nxt.result_index     = resid_r;
          res_nxt.slot_address     = addr_r;
          res_nxt.page_added       = added_r;
          res_nxt.new_page_address = newbase_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      end_r       <= ADDR_W'(RST_START_ADDR);
      full_r      <= '0;
      out_valid_r <= 1'b0;
      start_r     <= RST_START_ADDR;
      root_r      <= RST_ROOT_OFFSET;
      pbytes_r    <= RST_PAGE_BYTES;
      hdr_r       <= RST_HDR_BYTES;
      sbytes_r    <= RST_SLOT_BYTES;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      end_r       <= end_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
      root_r      <= root_nxt;
      pbytes_r    <= pbytes_nxt;
      hdr_r       <= hdr_nxt;
      sbytes_r    <= sbytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    page_r    <= page_nxt;
    bpos_r    <= bpos_nxt;
    chunk_r   <= chunk_nxt;
    status_r  <= status_nxt;
    resid_r   <= resid_nxt;
    addr_r    <= addr_nxt;
    added_r   <= added_nxt;
    newbase_r <= newbase_nxt;
    res_r     <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign res_o     = res_r;

endmodule

`default_nettype wire

>>> rtl/paged_bitmap_slot_allocator.sv
// -----------------------------------------------------------------------------
// Paged bitmap slot allocator
// First-fit slot allocator over pages of 64 slots with address translation.
// -----------------------------------------------------------------------------
// Requests enter on the in_ stream: tuser carries the operation (allocate,
// free, translate) and tdata the slot index. Every request gives exactly one
// response word on the out_ stream, in request order, with the status and
// page-added flag in tuser and the index and addresses in tdata.
// Registers must be written through cfg_ only while no request is in flight;
// the user keeps to this, as the block does not enforce it. A two-entry
// queue decouples request intake from execution. Free or translate of index
// zero and rejected requests go straight to the response; an allocate scans
// the pages in 16-page groups and then appends a page, reports a full table
// or reads the chosen page's map and base, and a free or translate reads the
// page's map and base first. The execution sequencer handles one request at
// a time, so a new request starts only after the last one has given its
// response word; it reads each page's map and base from single-read-port RAMs.
// Reset empties all pages, restores the register defaults and needs no
// clearing pass. When the receiver stalls, the response word holds; one more
// request finishes into the sequencer and two wait in the queue before
// in_tready falls.
// -----------------------------------------------------------------------------
`default_nettype none

module paged_bitmap_slot_allocator
  import pbsa_pkg::*;
#(
  parameter int MAX_PAGES = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Fields from bit 0: slot_index[10:0], zero fill.
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: operation[1:0].
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // Fields from bit 0: result_index[10:0], slot_address[42:11],
  // new_page_address[74:43], zero fill.
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // Fields from bit 0: status[1:0], page_added[2].
  output logic [OUT_TUSER_W-1:0]      out_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_AW-1:0]      cfg_addr,
  input  wire logic [CFG_DW-1:0]      cfg_wdata
);

  localparam int PAD_W = OUT_TDATA_W - IDX_W - 2 * ADDR_W;

  fe_out_t fe;
  logic    fe_pop;
  result_t res;

  pbsa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser[OP_W-1:0]),
    .in_idx   (in_tdata[IDX_W-1:0]),
    .fe_o     (fe),
    .fe_pop   (fe_pop)
  );

  pbsa_back #(
    .MAX_PAGES (MAX_PAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fe_i      (fe),
    .fe_pop    (fe_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_o     (res)
  );

  assign out_tdata = {{PAD_W{1'b0}}, res.new_page_address, res.slot_address,
                      res.result_index};
  assign out_tuser = {res.page_added, res.status};

endmodule

`default_nettype wire

>>> rtl/pbsa_checker.sv
// -----------------------------------------------------------------------------
// Paged bitmap slot allocator port checker
// Checks response words on the top level's output stream over time.
// -----------------------------------------------------------------------------
`default_nettype none
`include "paged_bitmap_slot_allocator_defines.svh"

module pbsa_checker
  import pbsa_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready
);

  `PBSA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled response word changed")
  `PBSA_ASSERT_NOW(a_added_ok, out_tvalid && out_tuser[2], out_tuser[1:0] == ST_OK, "page added with a failing status")
  `PBSA_ASSERT_NOW(a_added_first, out_tvalid && out_tuser[2], out_tdata[5:0] == 6'd1, "new page did not give its first slot")
  `PBSA_ASSERT_NOW(a_full_zero, out_tvalid && (out_tuser[1:0] == ST_FULL), (out_tdata[42:0] == 43'd0) && !out_tuser[2], "table full response carries data")

endmodule

bind paged_bitmap_slot_allocator pbsa_checker u_pbsa_checker (.*);

`default_nettype wire
